// ===== sv/tshrp_pkg.sv =====
// Package with status codes, character codes and the result type of the hex record parser.
package tshrp_pkg;

    localparam int DATA_BYTES = 4;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_N   = 8'h4e;
    localparam logic [7:0] CH_D   = 8'h44;

    localparam logic [15:0] MAX_LINES_RESET = 16'd720;

    localparam logic [2:0] ST_RECORD    = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_IMAGE_END = 3'd2;
    localparam logic [2:0] ST_ZERO      = 3'd3;
    localparam logic [2:0] ST_BAD_FIELD = 3'd4;
    localparam logic [2:0] ST_TOO_MANY  = 3'd5;

    localparam logic [2:0] LAST_FIELD = 3'd7;
    localparam logic [2:0] LEN_CAP    = (DATA_BYTES > 7) ? 3'd7 : 3'(DATA_BYTES);

    localparam int TDATA_W = 72;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] config_id;
        logic [7:0]  page_num;
        logic [7:0]  register_address;
        logic [31:0] register_data;
        logic [2:0]  data_length;
        logic        run_end;
    } result_t;

    function automatic result_t make_status(input logic [2:0] st);
        result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

endpackage

// ===== sv/tab_separated_hex_record_parser.sv =====
// Top level of the tab-separated hex record parser with its three-entry result queue.
// A result enters the registered result queue in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the result queue holds at most one result; with two or
// more queued, s_tready is low until the master side drains them, one result per cycle while m_tready is high.
// Reset: synchronous, active low on aresetn; all parser state and the line count are cleared,
// the queue count is cleared, which empties the queue, and max_lines returns to 720.
module tab_separated_hex_record_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [15:0]                   cfg_wdata,     // max_lines
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,       // data_byte
    input  logic                          s_tlast,       // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tshrp_pkg::TDATA_W-1:0] m_tdata,
    // config_id[15:0], page_num[23:16], register_address[31:24],
    // register_data[63:32], data_length[66:64], zero fill above
    output logic [2:0]                    m_tuser,       // status
    output logic                          m_tlast        // run_end
);
    import tshrp_pkg::*;

    logic [15:0] max_lines_reg;
    logic [2:0]  field_index_reg, field_index_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  digit_count_reg, digit_count_next;
    logic [1:0]  end_prog_reg, end_prog_next;
    logic        skip_reg, skip_next;
    logic        halted_reg, halted_next;
    logic [15:0] line_count_reg, line_count_next;
    logic [15:0] held_cid_reg, held_cid_next;
    logic [7:0]  held_page_reg, held_page_next;
    logic [7:0]  held_addr_reg, held_addr_next;
    logic [31:0] held_data_reg, held_data_next;
    logic [2:0]  held_len_reg, held_len_next;

    result_t     queue_reg [3];
    result_t     queue_next [3];
    logic [1:0]  count_reg, count_next;

    result_t     res0, res1;
    logic [1:0]  n_res;
    logic        s_accept, m_pop;
    logic [1:0]  base;

    logic [7:0]  b;
    logic        is_hex;
    logic [3:0]  hex_val;
    logic [8:0]  len_sum;
    logic [7:0]  len_half;
    logic [2:0]  len_clamped;
    logic [16:0] line_inc;

    assign s_tready = (count_reg <= 2'd1);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_pop    = m_tvalid && m_tready;

    assign m_tuser = queue_reg[0].status;
    assign m_tlast = queue_reg[0].run_end;
    assign m_tdata = {5'd0, queue_reg[0].data_length, queue_reg[0].register_data,
                      queue_reg[0].register_address, queue_reg[0].page_num,
                      queue_reg[0].config_id};

    assign b = s_tdata;

    always_comb begin
        is_hex  = 1'b0;
        hex_val = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            is_hex  = 1'b1;
            hex_val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            is_hex  = 1'b1;
            hex_val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            is_hex  = 1'b1;
            hex_val = 4'(b - 8'h37);
        end
    end

    assign len_sum     = {1'b0, digit_count_reg} + 9'd1;
    assign len_half    = len_sum[8:1];
    assign len_clamped = (len_half > {5'd0, LEN_CAP}) ? LEN_CAP : len_half[2:0];
    assign line_inc    = {1'b0, line_count_reg} + 17'd1;

    always_comb begin
        field_index_next = field_index_reg;
        acc_next         = acc_reg;
        digit_count_next = digit_count_reg;
        end_prog_next    = end_prog_reg;
        skip_next        = skip_reg;
        halted_next      = halted_reg;
        line_count_next  = line_count_reg;
        held_cid_next    = held_cid_reg;
        held_page_next   = held_page_reg;
        held_addr_next   = held_addr_reg;
        held_data_next   = held_data_reg;
        held_len_next    = held_len_reg;
        res0             = '0;
        res1             = '0;
        n_res            = 2'd0;

        if (s_accept && !halted_reg) begin
            if (skip_reg) begin
                skip_next     = 1'b0;
                end_prog_next = 2'd0;
            end else if (b == 8'h00) begin
                res0        = make_status(ST_ZERO);
                n_res       = 2'd1;
                halted_next = 1'b1;
            end else begin
                if (end_prog_reg == 2'd2 && b == CH_D) begin
                    res0        = make_status(ST_END);
                    n_res       = 2'd1;
                    halted_next = 1'b1;
                end else if (end_prog_reg == 2'd1 && b == CH_N) begin
                    end_prog_next = 2'd2;
                end else if (field_index_reg == 3'd0 && b == CH_E) begin
                    end_prog_next = 2'd1;
                end else begin
                    end_prog_next = 2'd0;
                end

                if (!halted_next) begin
                    if (b != CH_TAB && b != CH_CR) begin
                        if (is_hex) begin
                            acc_next = {acc_reg[27:0], hex_val};
                            if (digit_count_reg != 8'hff) begin
                                digit_count_next = digit_count_reg + 8'd1;
                            end
                        end
                    end else if (field_index_reg == LAST_FIELD) begin
                        res0        = make_status(ST_BAD_FIELD);
                        n_res       = 2'd1;
                        halted_next = 1'b1;
                    end else begin
                        unique case (field_index_reg)
                            3'd0: held_cid_next  = acc_reg[15:0];
                            3'd1: held_page_next = acc_reg[7:0];
                            3'd2: held_addr_next = acc_reg[7:0];
                            3'd5: begin
                                held_data_next = acc_reg;
                                held_len_next  = len_clamped;
                            end
                            default: ;
                        endcase
                        acc_next         = '0;
                        digit_count_next = '0;
                        if (b == CH_TAB) begin
                            field_index_next = field_index_reg + 3'd1;
                        end else begin
                            field_index_next = '0;
                            if (line_inc > {1'b0, max_lines_reg}) begin
                                res0        = make_status(ST_TOO_MANY);
                                n_res       = 2'd1;
                                halted_next = 1'b1;
                            end else begin
                                line_count_next        = line_inc[15:0];
                                res0.status            = ST_RECORD;
                                res0.config_id         = held_cid_next;
                                res0.page_num          = held_page_next;
                                res0.register_address  = held_addr_next;
                                res0.register_data     = held_data_next;
                                res0.data_length       = held_len_next;
                                res0.run_end           = 1'b0;
                                n_res                  = 2'd1;
                                held_cid_next          = '0;
                                held_page_next         = '0;
                                held_addr_next         = '0;
                                held_data_next         = '0;
                                held_len_next          = '0;
                                skip_next              = 1'b1;
                            end
                        end
                    end
                end
            end

            if (s_tlast && !halted_next) begin
                halted_next = 1'b1;
                if (n_res == 2'd0) begin
                    res0  = make_status(ST_IMAGE_END);
                    n_res = 2'd1;
                end else begin
                    res1  = make_status(ST_IMAGE_END);
                    n_res = 2'd2;
                end
            end

            if (n_res == 2'd1) begin
                res0.run_end = 1'b1;
            end else if (n_res == 2'd2) begin
                res1.run_end = 1'b1;
            end
        end
    end

    assign base       = count_reg - {1'b0, m_pop};
    assign count_next = base + n_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_lines_reg   <= MAX_LINES_RESET;
            field_index_reg <= '0;
            acc_reg         <= '0;
            digit_count_reg <= '0;
            end_prog_reg    <= '0;
            skip_reg        <= 1'b0;
            halted_reg      <= 1'b0;
            line_count_reg  <= '0;
            held_cid_reg    <= '0;
            held_page_reg   <= '0;
            held_addr_reg   <= '0;
            held_data_reg   <= '0;
            held_len_reg    <= '0;
            count_reg       <= '0;
        end else begin
            if (cfg_we) begin
                max_lines_reg <= cfg_wdata;
            end
            field_index_reg <= field_index_next;
            acc_reg         <= acc_next;
            digit_count_reg <= digit_count_next;
            end_prog_reg    <= end_prog_next;
            skip_reg        <= skip_next;
            halted_reg      <= halted_next;
            line_count_reg  <= line_count_next;
            held_cid_reg    <= held_cid_next;
            held_page_reg   <= held_page_next;
            held_addr_reg   <= held_addr_next;
            held_data_reg   <= held_data_next;
            held_len_reg    <= held_len_next;
            count_reg       <= count_next;
        end
    end

    // The queue shifts toward the head on a pop, and new results land right behind the survivors.
    always_comb begin
        queue_next[0] = queue_reg[0];
        queue_next[1] = queue_reg[1];
        queue_next[2] = queue_reg[2];
        if (m_pop) begin
            queue_next[0] = queue_reg[1];
            queue_next[1] = queue_reg[2];
        end
        if (n_res != 2'd0) begin
            unique case (base)
                2'd0: begin
                    queue_next[0] = res0;
                    queue_next[1] = res1;
                end
                2'd1: begin
                    queue_next[1] = res0;
                    queue_next[2] = res1;
                end
                default: begin
                    queue_next[2] = res0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        queue_reg[0] <= queue_next[0];
        queue_reg[1] <= queue_next[1];
        queue_reg[2] <= queue_next[2];
    end

    a_halt_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("Parser left the halted state without a reset.");

    a_skip_field0 : assert property (@(posedge aclk) disable iff (!aresetn)
        skip_reg |-> (field_index_reg == 3'd0))
        else $error("Byte skip is pending outside the first field.");

    a_last_halts : assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> halted_reg)
        else $error("Final image byte did not halt the parser.");

    a_no_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd3) |-> !s_tready)
        else $error("Slave side is ready with a full result queue.");

    a_halt_silent : assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (n_res == 2'd0))
        else $error("Halted parser produced a result.");

endmodule

// ===== test/tab_separated_hex_record_parser_tb.sv =====
// Self-checking testbench for the tab-separated hex record parser, with its own parsing predictor.
`timescale 1ns / 1ps

module tab_separated_hex_record_parser_tb;
    import tshrp_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT = 5000;

    typedef enum int {
        TERM_LAST_PLAIN,
        TERM_LAST_ON_CR,
        TERM_LAST_ON_SKIP,
        TERM_ZERO,
        TERM_END,
        TERM_BAD_FIELD,
        TERM_TOO_MANY
    } term_kind_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [15:0]         cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [2:0]          m_tuser;
    logic                m_tlast;

    int idle_pct;
    int stall_pct;
    int bytes_sent = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    // Predictor state of the parser.
    logic [15:0] line_limit = MAX_LINES_RESET;
    logic [2:0]  fld_idx = '0;
    logic [31:0] acc = '0;
    logic [7:0]  digit_cnt = '0;
    logic [1:0]  end_seen = '0;
    logic        skip_pending = 1'b0;
    logic        parser_halted = 1'b0;
    logic [15:0] lines_done = '0;
    logic [15:0] hold_cid = '0;
    logic [7:0]  hold_page = '0;
    logic [7:0]  hold_addr = '0;
    logic [31:0] hold_data = '0;
    logic [2:0]  hold_len = '0;

    result_t awaited_results[$];
    result_t got_head;

    tab_separated_hex_record_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic result_t status_only(input logic [2:0] st);
        result_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        result_t outs [2];
        result_t rec;
        int n;
        int nib;
        int len_calc;
        logic first_field;
        n = 0;
        if (parser_halted) return;
        if (skip_pending) begin
            skip_pending = 1'b0;
            end_seen = 2'd0;
        end else if (b == 8'h00) begin
            outs[n] = status_only(ST_ZERO);
            n++;
            parser_halted = 1'b1;
        end else begin
            first_field = (fld_idx == 3'd0);
            if (end_seen == 2'd2 && b == CH_D) begin
                outs[n] = status_only(ST_END);
                n++;
                parser_halted = 1'b1;
            end else if (end_seen == 2'd1 && b == CH_N) begin
                end_seen = 2'd2;
            end else if (first_field && b == CH_E) begin
                end_seen = 2'd1;
            end else begin
                end_seen = 2'd0;
            end
            if (!parser_halted) begin
                if (b != CH_TAB && b != CH_CR) begin
                    nib = hex_nibble(b);
                    if (nib >= 0) begin
                        acc = {acc[27:0], 4'(nib)};
                        if (digit_cnt != 8'hff) digit_cnt++;
                    end
                end else if (fld_idx == LAST_FIELD) begin
                    outs[n] = status_only(ST_BAD_FIELD);
                    n++;
                    parser_halted = 1'b1;
                end else begin
                    case (fld_idx)
                        3'd0: hold_cid = acc[15:0];
                        3'd1: hold_page = acc[7:0];
                        3'd2: hold_addr = acc[7:0];
                        3'd5: begin
                            hold_data = acc;
                            len_calc = (int'(digit_cnt) + 1) / 2;
                            if (len_calc > int'(LEN_CAP)) len_calc = int'(LEN_CAP);
                            hold_len = 3'(len_calc);
                        end
                        default: ;
                    endcase
                    acc = '0;
                    digit_cnt = '0;
                    if (b == CH_TAB) begin
                        fld_idx++;
                    end else begin
                        fld_idx = 3'd0;
                        if (int'(lines_done) + 1 > int'(line_limit)) begin
                            outs[n] = status_only(ST_TOO_MANY);
                            n++;
                            parser_halted = 1'b1;
                        end else begin
                            lines_done++;
                            rec = '0;
                            rec.status = ST_RECORD;
                            rec.config_id = hold_cid;
                            rec.page_num = hold_page;
                            rec.register_address = hold_addr;
                            rec.register_data = hold_data;
                            rec.data_length = hold_len;
                            outs[n] = rec;
                            n++;
                            hold_cid = '0;
                            hold_page = '0;
                            hold_addr = '0;
                            hold_data = '0;
                            hold_len = '0;
                            skip_pending = 1'b1;
                        end
                    end
                end
            end
        end
        if (last && !parser_halted) begin
            outs[n] = status_only(ST_IMAGE_END);
            n++;
            parser_halted = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            rec = outs[k];
            rec.run_end = (k == n - 1);
            awaited_results.push_back(rec);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_lines(input logic [15:0] v);
        wait_results_done();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        line_limit = v;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // A D that would complete an END marker is swapped for a dot.
    task automatic send_safe(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (end_seen == 2'd2 && v == CH_D) v = 8'h2e;
        send_byte(v, 1'b0);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return 8'h30 + 8'(v);
        if ($urandom_range(1)) return 8'h61 + 8'(v - 10);
        return 8'h41 + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255, 1));
        if (b == CH_TAB || b == CH_CR) b = 8'h20;
        return b;
    endfunction

    task automatic send_field_text(input int n, input int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) send_safe(rand_noise());
            send_safe(rand_hex_char());
        end
    endtask

    task automatic send_record_line(input int nfields, input int max_digits, input int noise_pct);
        for (int f = 0; f < nfields; f++) begin
            if (f != 0) send_byte(CH_TAB, 1'b0);
            send_field_text($urandom_range(max_digits), noise_pct);
        end
        send_byte(CH_CR, 1'b0);
        if ($urandom_range(99) < 85) send_byte(8'h0a, 1'b0);
        else send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_random_line();
        int shape;
        shape = $urandom_range(99);
        if (shape < 70) begin
            send_record_line($urandom_range(7, 6), 10, 5);
        end else if (shape < 85) begin
            send_record_line($urandom_range(7, 1), 12, 30);
        end else if (shape < 90) begin
            send_safe(CH_E);
            send_safe(CH_N);
            send_safe(CH_D);
            send_record_line(7, 8, 5);
        end else if (shape < 95) begin
            send_record_line($urandom_range(7, 1), 0, 0);
        end else begin
            send_record_line(7, 40, 2);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int budget, input bit hold);
        int start;
        bit held;
        idle_pct = idle;
        stall_pct = stall;
        start = bytes_sent;
        held = 1'b0;
        while (bytes_sent - start < budget) begin
            send_random_line();
            if (hold && !held && bytes_sent - start >= budget / 2) begin
                wait_results_done();
                held = 1'b1;
            end
        end
        wait_results_done();
    endtask

    task automatic test_line_limit();
        write_max_lines(16'd1);
        send_text("abcd\t12\t34\t\t\t5678\r\n");
        write_max_lines(16'hffff);
    endtask

    task automatic test_field_extremes();
        send_text("FFFF\tFF\tFF\tF\tF\tFFFFFFFF\tF\r\n");
        send_text("0\t0\t0\t0\t0\t0\r");
        send_byte(8'h00, 1'b0);
        send_text("1a2B\tc\t9d\t/:@G`g\t");
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_text("\t0aBcDeF12\r\r");
        send_text("\r\n");
        send_text("12345\t6789a\tbcdef\t\t\t123\r\n");
        send_text("7\t\t\t\t\tz?\r\n");
    endtask

    task automatic test_end_lookalikes();
        send_text("1\tEND\r\n");
        send_text("ENxD\t2\r\n");
        send_text("E\tND\r\n");
        send_text("EN\rD");
    endtask

    task automatic test_digit_saturation();
        send_text("1\t2\t3\t\t\t");
        for (int i = 0; i < 257; i++) send_byte(rand_hex_char(), 1'b0);
        send_text("\r\n");
        wait_results_done();
    endtask

    task automatic test_random_stream();
        run_phase(0, 0, 280, 1'b0);
        write_max_lines(MAX_LINES_RESET);
        run_phase(84, 0, 280, 1'b1);
        write_max_lines(lines_done + 16'd300);
        run_phase(0, 84, 280, 1'b0);
        write_max_lines(16'hffff);
        run_phase(31, 31, 280, 1'b0);
    endtask

    task automatic test_terminal_event();
        term_kind_t kind;
        logic tail_last;
        kind = term_kind_t'($urandom_range(TERM_TOO_MANY));
        tail_last = 1'($urandom_range(1));
        idle_pct = 31;
        stall_pct = 31;
        case (kind)
            TERM_LAST_PLAIN: begin
                send_text("12\t3");
                send_byte(8'h34, 1'b1);
            end
            TERM_LAST_ON_CR: begin
                send_text("5\t6\t7\t\t\t89");
                send_byte(CH_CR, 1'b1);
            end
            TERM_LAST_ON_SKIP: begin
                send_text("5\t6\t7\t\t\t89\r");
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            TERM_ZERO: begin
                send_text("1\t2");
                send_byte(8'h00, tail_last);
            end
            TERM_END: begin
                send_text("EN");
                send_byte(CH_D, tail_last);
            end
            TERM_BAD_FIELD: begin
                send_text("1\t2\t3\t4\t5\t6\t7\t8");
                send_byte($urandom_range(1) ? CH_TAB : CH_CR, tail_last);
            end
            default: begin
                write_max_lines(lines_done + 16'd1);
                send_record_line(7, 8, 5);
                send_text("1\t2\t3\t\t\t4");
                send_byte(CH_CR, tail_last);
            end
        endcase
        for (int i = 0; i < 8; i++) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: status %0d", m_tuser);
                fail_count++;
            end else begin
                got_head = awaited_results.pop_front();
                check_field("status", got_head.status, m_tuser);
                check_field("config_id", got_head.config_id, m_tdata[15:0]);
                check_field("page_num", got_head.page_num, m_tdata[23:16]);
                check_field("register_address", got_head.register_address, m_tdata[31:24]);
                check_field("register_data", got_head.register_data, m_tdata[63:32]);
                check_field("data_length", got_head.data_length, m_tdata[66:64]);
                check_field("tdata fill", 32'd0, m_tdata[TDATA_W-1:67]);
                check_field("run_end", got_head.run_end, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_line_limit();
        test_field_extremes();
        test_end_lookalikes();
        test_digit_saturation();
        test_random_stream();
        test_terminal_event();
        wait_results_done();
        if (fail_count == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tshrp_pkg.sv
sv/tab_separated_hex_record_parser.sv
test/tab_separated_hex_record_parser_tb.sv
